// ===== rtl/isort_pkg.sv =====
// Package for the insertion sorter: shared constants and the command and
// status structs that join the controller and the datapath.
// Depends on nothing.
`timescale 1ns / 1ps

package isort_pkg;

    localparam int VALUE_W          = 32;
    localparam int DEFAULT_CAPACITY = 32;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic insert;  // insert the input value into the list
        logic shift;   // emit the head entry and move the list down one place
    } isort_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic count_one;  // exactly one entry is left in the list
    } isort_status_t;

endpackage

// ===== rtl/isort_ctrl.sv =====
// Controller of the insertion sorter: accepts insert beats and sequences
// the emission of the sorted list. Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  last,
    input  isort_pkg::isort_status_t status,
    output isort_pkg::isort_cmd_t    cmd,
    output logic                  busy,
    output logic                  valid
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic state_reg;
    logic state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.insert = 1'b1;
                    if (last)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                cmd.shift = 1'b1;
                if (status.count_one)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy  = (state_reg == ST_EMIT);
    assign valid = (state_reg == ST_EMIT);

endmodule

// ===== rtl/isort_datapath.sv =====
// Datapath of the insertion sorter: a row of value cells that insert in
// parallel and shift out from the head, plus fill count and drop flag.
// Depends on isort_pkg.
`timescale 1ns / 1ps

module isort_datapath
#(
    parameter int CAPACITY = isort_pkg::DEFAULT_CAPACITY
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  isort_pkg::isort_cmd_t               cmd,
    input  logic signed [isort_pkg::VALUE_W-1:0] value,
    output isort_pkg::isort_status_t            status,
    output logic signed [isort_pkg::VALUE_W-1:0] sorted_value,
    output logic                                final_res,
    output logic                                overflow
);

    localparam int CW = $clog2(CAPACITY + 1);

    logic signed [isort_pkg::VALUE_W-1:0] list_reg  [CAPACITY];
    logic signed [isort_pkg::VALUE_W-1:0] list_next [CAPACITY];
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;
    logic          drop_reg;
    logic          drop_next;
    logic [CAPACITY-1:0] gt;
    logic [CAPACITY-1:0] ins_here;
    logic          full;
    logic          count_one;

    assign full      = (count_reg == CW'(CAPACITY));
    assign count_one = (count_reg == CW'(1));

    // Per-cell compare: cells above the insert point hold larger values.
    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            gt[i]       = (CW'(i) < count_reg) && (list_reg[i] > value);
            ins_here[i] = gt[i] || (CW'(i) == count_reg);
        end
    end

    always_comb
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            list_next[i] = list_reg[i];
            if (cmd.shift)
            begin
                if (i < CAPACITY - 1)
                begin
                    list_next[i] = list_reg[(i < CAPACITY - 1) ? i + 1 : i];
                end
            end
            else if (cmd.insert && !full)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    list_next[i] = list_reg[(i > 0) ? i - 1 : 0];
                end
                else if (ins_here[i])
                begin
                    list_next[i] = value;
                end
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        drop_next  = drop_reg;
        if (cmd.shift)
        begin
            count_next = count_reg - CW'(1);
            if (count_one)
            begin
                drop_next = 1'b0;
            end
        end
        else if (cmd.insert)
        begin
            if (full)
            begin
                drop_next = 1'b1;
            end
            else
            begin
                count_next = count_reg + CW'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            drop_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            drop_reg  <= drop_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < CAPACITY; i++)
        begin
            list_reg[i] <= list_next[i];
        end
    end

    assign status.count_one = count_one;
    assign sorted_value     = list_reg[0];
    assign final_res        = count_one;
    assign overflow         = drop_reg;

endmodule

// ===== rtl/insertion_sorter.sv =====
// Stable insertion sorter for signed 32-bit values. An insert beat is taken
// while idle; a beat marked last is inserted and then the list of entries is
// emitted back to back, starting the cycle after acceptance, one result per
// cycle (the receiver cannot stall). Busy is high during emission. Reset is
// asynchronous, active low, and empties the list and clears the overflow
// flag.
`timescale 1ns / 1ps

module insertion_sorter
#(
    parameter int CAPACITY = isort_pkg::DEFAULT_CAPACITY
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic signed [isort_pkg::VALUE_W-1:0] value,
    input  logic                                last,
    output logic                                valid,
    output logic signed [isort_pkg::VALUE_W-1:0] sorted_value,
    output logic                                final_res,
    output logic                                overflow
);

    // The controller decides when the datapath inserts and when it shifts
    // the head entry out; the datapath reports when one entry remains.
    isort_pkg::isort_cmd_t    cmd;
    isort_pkg::isort_status_t status;

    // The controller treats start as a beat only while it is not busy,
    // which it guarantees by never sampling start outside the idle state.
    isort_ctrl u_ctrl
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .last   (last),
        .status (status),
        .cmd    (cmd),
        .busy   (busy),
        .valid  (valid)
    );

    // All cells compare against the new value at once, so an insert is a
    // parallel shift of the cells above the insert point; a full list drops the
    // value and marks the set as overflowed.
    isort_datapath #(
        .CAPACITY (CAPACITY)
    ) u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .value        (value),
        .status       (status),
        .sorted_value (sorted_value),
        .final_res    (final_res),
        .overflow     (overflow)
    );

endmodule
